// ===== rtl/ctv_pkg.sv =====
// Shared types, widths and arithmetic helpers for the circle tangent vector core.
// Used by the sqrt cells, the divider cells and the top level.
package ctv_pkg;

  localparam int CW = 32;
  localparam int SW = 2 * CW;
  localparam int NW = 3 * CW;
  localparam int WX = CW + 3;

  typedef enum logic [1:0] {
    CASE_OUTSIDE    = 2'd0,
    CASE_BOUNDARY   = 2'd1,
    CASE_INSIDE     = 2'd2,
    CASE_ZERO_POINT = 2'd3
  } case_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic [CW-2:0]        radius;
    logic                 side_negative;
    logic signed [CW-1:0] test_x;
    logic signed [CW-1:0] test_y;
  } query_t;

  typedef struct packed {
    logic signed [CW-1:0] tangent_x;
    logic signed [CW-1:0] tangent_y;
    logic                 side_ok;
    case_t                case_code;
    logic                 saturated;
  } answer_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] test_x;
    logic signed [CW-1:0] test_y;
    logic [CW-2:0]        rad;
    logic                 eneg;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;
    logic [SW-1:0]        s_sq;
    logic [SW-1:0]        d_sq;
    case_t                code;
    logic [SW-1:0]        srem;
    logic [CW-1:0]        root;
    logic [SW-1:0]        dr;
    logic [7:0][SW-1:0]   pp;
    logic [3:0][NW-1:0]   mg;
    logic                 nx_neg;
    logic                 ny_neg;
    logic [SW-1:0]        remx;
    logic [SW-1:0]        remy;
    logic [CW-1:0]        numx;
    logic [CW-1:0]        numy;
    logic [CW-1:0]        qx;
    logic [CW-1:0]        qy;
  } pipe_t;

  typedef struct packed {
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic                 sat;
    case_t                code;
    logic                 eneg;
    logic signed [CW-1:0] test_x;
    logic signed [CW-1:0] test_y;
    logic signed [SW-1:0] p1;
    logic signed [SW-1:0] p2;
  } post_t;

  function automatic logic [SW-1:0] umul(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return SW'(a) * SW'(b);
  endfunction

  function automatic logic [SW-1:0] smul(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return {{CW{a[CW-1]}}, a} * {{CW{b[CW-1]}}, b};
  endfunction

  // returns {sign, magnitude} of (an ? -a : a) + (bn ? -b : b)
  function automatic logic [NW:0] sadd(input logic [NW-1:0] a, input logic an,
                                       input logic [NW-1:0] b, input logic bn);
    logic [NW:0] r;
    if (an == bn) begin
      r = {an, a + b};
    end else if (a >= b) begin
      r = {an, a - b};
    end else begin
      r = {bn, b - a};
    end
    return r;
  endfunction

  // returns {clipped, value}
  function automatic logic [CW:0] sat_cw(input logic signed [WX-1:0] v);
    logic signed [WX-1:0] smax;
    logic signed [WX-1:0] smin;
    logic [CW:0] r;
    smax = {{(WX-CW+1){1'b0}}, {(CW-1){1'b1}}};
    smin = {{(WX-CW+1){1'b1}}, {(CW-1){1'b0}}};
    if (v > smax) begin
      r = {1'b1, smax[CW-1:0]};
    end else if (v < smin) begin
      r = {1'b1, smin[CW-1:0]};
    end else begin
      r = {1'b0, v[CW-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/ctv_sqrt_cell.sv =====
// One digit of the integer square root of the squared-distance difference.
// Depends on ctv_pkg for the pipeline item type.
module ctv_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          load,
  input  ctv_pkg::pipe_t d,
  output ctv_pkg::pipe_t q
);

  logic [ctv_pkg::SW:0] trial;
  logic [ctv_pkg::SW:0] rem_ext;
  ctv_pkg::pipe_t       nxt;

  always_comb begin
    trial   = ({{(ctv_pkg::SW + 1 - ctv_pkg::CW){1'b0}}, d.root} << (STEP + 1))
            + ((ctv_pkg::SW + 1)'(1) << (2 * STEP));
    rem_ext = {1'b0, d.srem};
    nxt     = d;
    if (rem_ext >= trial) begin
      nxt.srem       = ctv_pkg::SW'(rem_ext - trial);
      nxt.root[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= nxt;
    end
  end

endmodule

// ===== rtl/ctv_div_cell.sv =====
// One quotient bit of both tangent-point divisions by the squared distance.
// Depends on ctv_pkg for the pipeline item type.
module ctv_div_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          load,
  input  ctv_pkg::pipe_t d,
  output ctv_pkg::pipe_t q
);

  logic [ctv_pkg::SW:0] rx;
  logic [ctv_pkg::SW:0] ry;
  logic [ctv_pkg::SW:0] den;
  ctv_pkg::pipe_t       nxt;

  always_comb begin
    rx  = {d.remx, d.numx[STEP]};
    ry  = {d.remy, d.numy[STEP]};
    den = {1'b0, d.s_sq};
    nxt = d;
    if (rx >= den) begin
      nxt.remx     = ctv_pkg::SW'(rx - den);
      nxt.qx[STEP] = 1'b1;
    end else begin
      nxt.remx = rx[ctv_pkg::SW-1:0];
    end
    if (ry >= den) begin
      nxt.remy     = ctv_pkg::SW'(ry - den);
      nxt.qy[STEP] = 1'b1;
    end else begin
      nxt.remy = ry[ctv_pkg::SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= nxt;
    end
  end

endmodule

// ===== rtl/circle_tangent_vector_core.sv =====
// One item per cycle while query_ready is high; query_ready drops while the skid entry is held.
// The depth is set mainly by the sqrt cell chain (one root bit per cell) and the divider
// cell chain (one quotient bit per cell). A two-entry output stage keeps taking
// items while one answer waits. Synchronous reset empties the pipe, tolerance = 64.
// Depends on ctv_pkg, ctv_sqrt_cell and ctv_div_cell.
module circle_tangent_vector_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             query_valid,
  output logic             query_ready,
  input  ctv_pkg::query_t  query,
  output logic             answer_valid,
  input  logic             answer_ready,
  output ctv_pkg::answer_t answer,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data
);

  localparam int CW  = ctv_pkg::CW;
  localparam int SW  = ctv_pkg::SW;
  localparam int NW  = ctv_pkg::NW;
  localparam int WX  = ctv_pkg::WX;
  localparam int SQ0 = 3;
  localparam int M1  = SQ0 + CW;
  localparam int M2  = M1 + 1;
  localparam int M3  = M1 + 2;
  localparam int M4  = M1 + 3;
  localparam int DV0 = M4 + 1;
  localparam int NP  = DV0 + CW;
  localparam int NV  = NP + 2;

  logic [31:0]      tol;
  logic             en;
  logic [NV-1:0]    vld;
  ctv_pkg::pipe_t   stg [NP];
  ctv_pkg::pipe_t   s0_next, s1_next, s2_next;
  ctv_pkg::pipe_t   m1_next, m2_next, m3_next, m4_next;
  ctv_pkg::post_t   r1, r1_next, r2, r2_next;
  ctv_pkg::answer_t res, skid;
  logic             skid_v;

  assign en          = !skid_v;
  assign query_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 32'd64;
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], query_valid};
    end
  end

  // squares of the magnitudes and of the radius
  always_comb begin
    s0_next        = '0;
    s0_next.pos_x  = query.pos_x;
    s0_next.pos_y  = query.pos_y;
    s0_next.test_x = query.test_x;
    s0_next.test_y = query.test_y;
    s0_next.rad    = query.radius;
    s0_next.eneg   = query.side_negative;
    s0_next.ax     = query.pos_x[CW-1] ? CW'(-query.pos_x) : query.pos_x;
    s0_next.ay     = query.pos_y[CW-1] ? CW'(-query.pos_y) : query.pos_y;
    s0_next.pp[0]  = ctv_pkg::umul(s0_next.ax, s0_next.ax);
    s0_next.pp[1]  = ctv_pkg::umul(s0_next.ay, s0_next.ay);
    s0_next.d_sq   = ctv_pkg::umul({1'b0, query.radius}, {1'b0, query.radius});
  end

  always_comb begin
    s1_next      = stg[0];
    s1_next.s_sq = stg[0].pp[0] + stg[0].pp[1];
  end

  // classify against the circle
  always_comb begin
    logic          ge;
    logic [SW-1:0] diff;
    s2_next = stg[1];
    ge      = stg[1].s_sq >= stg[1].d_sq;
    diff    = ge ? stg[1].s_sq - stg[1].d_sq : stg[1].d_sq - stg[1].s_sq;
    if (diff <= {{(SW-32){1'b0}}, tol}) begin
      s2_next.code = ctv_pkg::CASE_BOUNDARY;
    end else if (!ge) begin
      s2_next.code = ctv_pkg::CASE_INSIDE;
    end else begin
      s2_next.code = ctv_pkg::CASE_OUTSIDE;
    end
    s2_next.srem = diff;
    s2_next.root = '0;
  end

  always_comb begin
    m1_next    = stg[M1-1];
    m1_next.dr = ctv_pkg::umul({1'b0, stg[M1-1].rad}, stg[M1-1].root);
  end

  always_comb begin
    ctv_pkg::pipe_t p;
    p             = stg[M2-1];
    m2_next       = p;
    m2_next.pp[0] = ctv_pkg::umul(p.d_sq[CW-1:0], p.ax);
    m2_next.pp[1] = ctv_pkg::umul(p.d_sq[SW-1:CW], p.ax);
    m2_next.pp[2] = ctv_pkg::umul(p.dr[CW-1:0], p.ay);
    m2_next.pp[3] = ctv_pkg::umul(p.dr[SW-1:CW], p.ay);
    m2_next.pp[4] = ctv_pkg::umul(p.d_sq[CW-1:0], p.ay);
    m2_next.pp[5] = ctv_pkg::umul(p.d_sq[SW-1:CW], p.ay);
    m2_next.pp[6] = ctv_pkg::umul(p.dr[CW-1:0], p.ax);
    m2_next.pp[7] = ctv_pkg::umul(p.dr[SW-1:CW], p.ax);
  end

  always_comb begin
    m3_next = stg[M3-1];
    for (int i = 0; i < 4; i++) begin
      m3_next.mg[i] = NW'(stg[M3-1].pp[2*i]) + (NW'(stg[M3-1].pp[2*i+1]) << CW);
    end
  end

  // signed numerators, split into divider start remainder and low bits
  always_comb begin
    ctv_pkg::pipe_t p;
    logic [NW:0]    nx;
    logic [NW:0]    ny;
    p  = stg[M4-1];
    nx = ctv_pkg::sadd(p.mg[0], p.pos_x[CW-1], p.mg[1], p.pos_y[CW-1] ^ p.eneg);
    ny = ctv_pkg::sadd(p.mg[2], p.pos_y[CW-1], p.mg[3], ~(p.pos_x[CW-1] ^ p.eneg));
    m4_next        = p;
    m4_next.nx_neg = nx[NW];
    m4_next.ny_neg = ny[NW];
    m4_next.remx   = nx[NW-1:CW];
    m4_next.remy   = ny[NW-1:CW];
    m4_next.numx   = nx[CW-1:0];
    m4_next.numy   = ny[CW-1:0];
    m4_next.qx     = '0;
    m4_next.qy     = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0]  <= s0_next;
      stg[1]  <= s1_next;
      stg[2]  <= s2_next;
      stg[M1] <= m1_next;
      stg[M2] <= m2_next;
      stg[M3] <= m3_next;
      stg[M4] <= m4_next;
    end
  end

  for (genvar j = 0; j < CW; j++) begin : g_sqrt
    ctv_sqrt_cell #(.STEP(CW - 1 - j)) u_cell (
      .clk  (clk),
      .load (en),
      .d    (stg[SQ0+j-1]),
      .q    (stg[SQ0+j])
    );
  end

  for (genvar j = 0; j < CW; j++) begin : g_div
    ctv_div_cell #(.STEP(CW - 1 - j)) u_cell (
      .clk  (clk),
      .load (en),
      .d    (stg[DV0+j-1]),
      .q    (stg[DV0+j])
    );
  end

  // round, pick the case, subtract the position (outside case) and clip
  always_comb begin
    ctv_pkg::pipe_t       p;
    logic [CW:0]          qxm, qym;
    logic signed [WX-1:0] qxs, qys, sxe, sye, txw, tyw;
    logic [CW:0]          satx, saty;
    p       = stg[NP-1];
    qxm     = {1'b0, p.qx} + (CW+1)'({p.remx, 1'b0} >= {1'b0, p.s_sq});
    qym     = {1'b0, p.qy} + (CW+1)'({p.remy, 1'b0} >= {1'b0, p.s_sq});
    qxs     = p.nx_neg ? -$signed({2'b00, qxm}) : $signed({2'b00, qxm});
    qys     = p.ny_neg ? -$signed({2'b00, qym}) : $signed({2'b00, qym});
    sxe     = {{(WX-CW){p.pos_x[CW-1]}}, p.pos_x};
    sye     = {{(WX-CW){p.pos_y[CW-1]}}, p.pos_y};
    r1_next = '0;
    r1_next.eneg   = p.eneg;
    r1_next.test_x = p.test_x;
    r1_next.test_y = p.test_y;
    r1_next.code   = p.code;
    txw = '0;
    tyw = '0;
    case (p.code)
      ctv_pkg::CASE_BOUNDARY: begin
        txw = p.eneg ? -sye : sye;
        tyw = p.eneg ? sxe : -sxe;
      end
      ctv_pkg::CASE_OUTSIDE: begin
        if (qxm == '0 && qym == '0) begin
          r1_next.code = ctv_pkg::CASE_ZERO_POINT;
        end else begin
          txw = qxs - sxe;
          tyw = qys - sye;
        end
      end
      default: begin
        txw = '0;
        tyw = '0;
      end
    endcase
    satx       = ctv_pkg::sat_cw(txw);
    saty       = ctv_pkg::sat_cw(tyw);
    r1_next.tx  = satx[CW-1:0];
    r1_next.ty  = saty[CW-1:0];
    r1_next.sat = satx[CW] | saty[CW];
  end

  always_comb begin
    r2_next    = r1;
    r2_next.p1 = ctv_pkg::smul(r1.tx, r1.test_y);
    r2_next.p2 = ctv_pkg::smul(r1.ty, r1.test_x);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= r1_next;
      r2 <= r2_next;
    end
  end

  always_comb begin
    logic signed [SW:0] det;
    det           = {r2.p1[SW-1], r2.p1} - {r2.p2[SW-1], r2.p2};
    res.tangent_x = r2.tx;
    res.tangent_y = r2.ty;
    res.case_code = r2.code;
    res.saturated = r2.sat;
    res.side_ok   = r2.eneg ? (det[SW] || det == '0) : !det[SW];
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (skid_v) begin
      if (answer_ready) begin
        answer_valid <= 1'b1;
        skid_v       <= 1'b0;
      end
    end else if (!answer_valid || answer_ready) begin
      answer_valid <= vld[NV-1];
    end else if (vld[NV-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (answer_ready) begin
        answer <= skid;
      end
    end else if (!answer_valid || answer_ready) begin
      answer <= res;
    end else if (vld[NV-1]) begin
      skid <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> answer_valid)
    else $error("skid entry held with empty output register");

  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    answer_valid && answer.case_code == ctv_pkg::CASE_INSIDE |->
      answer.tangent_x == '0 && answer.tangent_y == '0 && !answer.saturated)
    else $error("inside case with nonzero tangent");

  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    answer_valid && answer.case_code == ctv_pkg::CASE_ZERO_POINT |->
      answer.tangent_x == '0 && answer.tangent_y == '0 && answer.side_ok)
    else $error("zero tangent point with nonzero tangent");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !answer_valid && query_ready)
    else $error("output not empty after reset");

endmodule
